[src/lbsb_pkg.sv]
package lbsb_pkg;

  localparam int NUM_BANDS_DEF    = 8;
  localparam int MAX_BIN_DEF      = 512;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int NUM_OUT          = 8;
  localparam int CNT_W            = 10;
  localparam int H_W              = 12;
  localparam int DT_W             = 10;
  localparam int SENS_W           = 7;
  localparam int SPEED_W          = 9;
  localparam int CFG_W            = 9;
  localparam int CFG_IDX_W        = 1;
  localparam int PEAK_W           = 64;
  localparam int DB_W             = 25;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [H_W-1:0] HEIGHT_MAX = 12'd2048;
  // x / 960 = (x >> 6) / 15; ceil(2^23 / 15), exact for 19-bit dividends
  localparam logic [19:0] DIV_RECIP = 20'd559241;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS  = 1'b0,
    REG_SPEED = 1'b1
  } cfg_reg_e;

  // elaboration-time log2 in Q16, same fixed-point scheme as the level path
  function automatic logic [63:0] log2_q16_f(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] m;
    logic [63:0] frac;
    int e;
    begin
      x = (x_in == 64'd0) ? 64'd1 : x_in;
      e = 0;
      frac = 64'd0;
      for (int i = 0; i < 63; i++) begin
        if ((x >> (i + 1)) != 64'd0) e = i + 1;
      end
      if (e <= 30) m = x << (30 - e);
      else m = x >> (e - 30);
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      return (64'(e) << 16) + frac;
    end
  endfunction

  function automatic int band_start_f(input int nb, input int mb, input int i);
    logic [63:0] top;
    logic [63:0] lim_n;
    int b;
    logic run;
    begin
      top = log2_q16_f(64'(mb));
      lim_n = top * 64'(i);
      b = 1;
      run = 1'b1;
      for (int j = 1; j < mb; j++) begin
        if (run && b == j && log2_q16_f(64'(j + 1)) * 64'(nb) <= lim_n) b = j + 1;
        else run = 1'b0;
      end
      if (i >= nb) b = mb;
      return b;
    end
  endfunction

endpackage

[src/log_band_spectrum_bars.sv]
// Channel   Handshake            Beat
// input     push / full          bin_real_i, bin_imag_i, last_bin_i, frame_dt_i
// result    empty / pop          height_band0_o .. height_band7_o
// config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// Bins are taken one per cycle while full is low; peak tracking is a two-stage
// multiply pipeline. A last bin blocks the input until its frame moves to the engine.
// Level engine, per band: load, 32 square-root steps, 1 to 33 normalize steps,
// 16 log squarings, dB, compare, divide. A waiting result stalls the engine in its
// output step. Reset is asynchronous.
module log_band_spectrum_bars #(
  parameter int NUM_BANDS    = lbsb_pkg::NUM_BANDS_DEF,
  parameter int MAX_BIN      = lbsb_pkg::MAX_BIN_DEF,
  parameter int SAMPLE_WIDTH = lbsb_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [31:0]                    bin_real_i,
  input  logic [31:0]                    bin_imag_i,
  input  logic                           last_bin_i,
  input  logic [lbsb_pkg::DT_W-1:0]      frame_dt_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [lbsb_pkg::H_W-1:0]       height_band0_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band1_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band2_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band3_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band4_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band5_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band6_o,
  output logic [lbsb_pkg::H_W-1:0]       height_band7_o,
  input  logic                           cfg_we_i,
  input  logic [lbsb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lbsb_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic frame_valid, frame_take;
  logic [lbsb_pkg::PEAK_W-1:0] frame_peak [NUM_BANDS];
  logic [lbsb_pkg::DT_W-1:0] frame_dt;
  logic [lbsb_pkg::H_W-1:0] height [lbsb_pkg::NUM_OUT];

  lbsb_front #(
    .NUM_BANDS(NUM_BANDS),
    .MAX_BIN(MAX_BIN),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .bin_real_i(bin_real_i),
    .bin_imag_i(bin_imag_i),
    .last_bin_i(last_bin_i),
    .frame_dt_i(frame_dt_i),
    .frame_valid_o(frame_valid),
    .frame_take_i(frame_take),
    .frame_peak_o(frame_peak),
    .frame_dt_o(frame_dt)
  );

  lbsb_back #(
    .NUM_BANDS(NUM_BANDS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .frame_valid_i(frame_valid),
    .frame_take_o(frame_take),
    .frame_peak_i(frame_peak),
    .frame_dt_i(frame_dt),
    .empty_o(empty),
    .pop_i(pop),
    .height_o(height)
  );

  assign height_band0_o = height[0];
  assign height_band1_o = height[1];
  assign height_band2_o = height[2];
  assign height_band3_o = height[3];
  assign height_band4_o = height[4];
  assign height_band5_o = height[5];
  assign height_band6_o = height[6];
  assign height_band7_o = height[7];

endmodule

[src/lbsb_front.sv]
module lbsb_front #(
  parameter int NUM_BANDS    = lbsb_pkg::NUM_BANDS_DEF,
  parameter int MAX_BIN      = lbsb_pkg::MAX_BIN_DEF,
  parameter int SAMPLE_WIDTH = lbsb_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [31:0]                   bin_real_i,
  input  logic [31:0]                   bin_imag_i,
  input  logic                          last_bin_i,
  input  logic [lbsb_pkg::DT_W-1:0]     frame_dt_i,
  output logic                          frame_valid_o,
  input  logic                          frame_take_i,
  output logic [lbsb_pkg::PEAK_W-1:0]   frame_peak_o [NUM_BANDS],
  output logic [lbsb_pkg::DT_W-1:0]     frame_dt_o
);

  localparam int BW = $clog2(NUM_BANDS);
  localparam int SW = SAMPLE_WIDTH;
  localparam logic [lbsb_pkg::CNT_W:0] MAX_IDX = (lbsb_pkg::CNT_W + 1)'(MAX_BIN);

  logic [lbsb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic accept;

  logic s1_v_q, s1_last_q, s1_inb_q;
  logic [BW-1:0] s1_band_q;
  logic [SW-1:0] s1_re_q, s1_im_q;
  logic [lbsb_pkg::DT_W-1:0] s1_dt_q;

  logic s2_v_q, s2_last_q, s2_inb_q;
  logic [BW-1:0] s2_band_q;
  logic [2*SW-1:0] s2_re2_q, s2_im2_q;
  logic [lbsb_pkg::DT_W-1:0] s2_dt_q;

  logic [lbsb_pkg::PEAK_W-1:0] peak_q [NUM_BANDS];
  logic [lbsb_pkg::PEAK_W-1:0] peak_nx [NUM_BANDS];
  logic [lbsb_pkg::PEAK_W-1:0] slot_peak_q [NUM_BANDS];
  logic [lbsb_pkg::DT_W-1:0] slot_dt_q;
  logic slot_v_q;

  logic [SW-1:0] re_raw, im_raw, re_abs, im_abs;
  logic inb;
  logic [BW-1:0] band;
  logic [NUM_BANDS-1:0] past_start;
  logic [lbsb_pkg::PEAK_W-1:0] pwr;
  logic fin;

  assign full_o = slot_v_q | (s1_v_q & s1_last_q) | (s2_v_q & s2_last_q);
  assign accept = push_i & ~full_o;

  assign re_raw = bin_real_i[SW-1:0];
  assign im_raw = bin_imag_i[SW-1:0];
  assign re_abs = re_raw[SW-1] ? (~re_raw + 1'b1) : re_raw;
  assign im_abs = im_raw[SW-1] ? (~im_raw + 1'b1) : im_raw;

  for (genvar g = 0; g < NUM_BANDS; g++) begin : g_band
    localparam int START = lbsb_pkg::band_start_f(NUM_BANDS, MAX_BIN, g);
    assign past_start[g] = ({1'b0, cnt_q} >= (lbsb_pkg::CNT_W + 1)'(START));
  end

  always_comb begin
    inb  = (cnt_q != '0) && ({1'b0, cnt_q} < MAX_IDX);
    band = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (past_start[b]) band = BW'(b);
    end
    cnt_d = cnt_q;
    if (accept) begin
      if (last_bin_i) cnt_d = '0;
      else if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
    end
  end

  assign pwr = lbsb_pkg::PEAK_W'(s2_re2_q) + lbsb_pkg::PEAK_W'(s2_im2_q);
  assign fin = s2_v_q & s2_last_q;

  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      peak_nx[b] = peak_q[b];
      if (s2_v_q && s2_inb_q && s2_band_q == BW'(b) && pwr > peak_q[b]) peak_nx[b] = pwr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      slot_v_q <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) peak_q[b] <= '0;
    end else begin
      cnt_q  <= cnt_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      for (int b = 0; b < NUM_BANDS; b++) peak_q[b] <= fin ? '0 : peak_nx[b];
      if (fin) slot_v_q <= 1'b1;
      else if (frame_take_i) slot_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= last_bin_i;
    s1_inb_q  <= inb;
    s1_band_q <= band;
    s1_re_q   <= re_abs;
    s1_im_q   <= im_abs;
    s1_dt_q   <= frame_dt_i;
    s2_last_q <= s1_last_q;
    s2_inb_q  <= s1_inb_q;
    s2_band_q <= s1_band_q;
    s2_re2_q  <= s1_re_q * s1_re_q;
    s2_im2_q  <= s1_im_q * s1_im_q;
    s2_dt_q   <= s1_dt_q;
    if (fin) begin
      slot_dt_q <= s2_dt_q;
      for (int b = 0; b < NUM_BANDS; b++) slot_peak_q[b] <= peak_nx[b];
    end
  end

  assign frame_valid_o = slot_v_q;
  assign frame_peak_o  = slot_peak_q;
  assign frame_dt_o    = slot_dt_q;

endmodule

[src/lbsb_back.sv]
module lbsb_back #(
  parameter int NUM_BANDS = lbsb_pkg::NUM_BANDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbsb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbsb_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              frame_valid_i,
  output logic                              frame_take_o,
  input  logic [lbsb_pkg::PEAK_W-1:0]       frame_peak_i [NUM_BANDS],
  input  logic [lbsb_pkg::DT_W-1:0]         frame_dt_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [lbsb_pkg::H_W-1:0]          height_o [lbsb_pkg::NUM_OUT]
);

  localparam int BW = $clog2(NUM_BANDS);
  localparam int DW = lbsb_pkg::DB_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,
    ST_SQRT = 9'b000000100,
    ST_NORM = 9'b000001000,
    ST_LOG  = 9'b000010000,
    ST_DB   = 9'b000100000,
    ST_CMP  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

  state_e st_q, st_d;
  logic [lbsb_pkg::SENS_W-1:0] sens_q;
  logic [lbsb_pkg::SPEED_W-1:0] speed_q;
  logic [BW-1:0] band_q;
  logic [lbsb_pkg::PEAK_W-1:0] peaks_q [NUM_BANDS];
  logic [12:0] decay_q;
  logic [lbsb_pkg::H_W-1:0] bars_q [NUM_BANDS];
  logic [63:0] v_q, r_q, bit_q;
  logic [32:0] x_q;
  logic [5:0] e_q;
  logic [30:0] m_q;
  logic [15:0] frac_q;
  logic [4:0] cnt_q;
  logic [DW-1:0] db_q, num_q;
  logic out_v_q;
  logic [lbsb_pkg::H_W-1:0] res_q [lbsb_pkg::NUM_OUT];

  logic [63:0] sum, v_nx, r_nx;
  logic [61:0] sq;
  logic [21:0] lq;
  logic [40:0] dbp;
  logic [23:0] thr;
  logic [38:0] qp;
  logic [15:0] quo;
  logic [lbsb_pkg::H_W-1:0] tgt;
  logic [19:0] dec_p;

  always_comb begin
    sum  = r_q + bit_q;
    v_nx = v_q;
    r_nx = r_q >> 1;
    if (v_q >= sum) begin
      v_nx = v_q - sum;
      r_nx = (r_q >> 1) + bit_q;
    end
    sq    = 62'(m_q) * 62'(m_q);
    lq    = {e_q[5:0], frac_q};
    dbp   = 41'(lq) * 41'(lbsb_pkg::DB_PER_LOG2) + 41'd32768;
    thr   = {8'(8'd150 - {1'b0, sens_q}), 16'd0};
    // divide by 960 as (num >> 6) / 15 by reciprocal
    qp    = 39'(num_q[DW-1:6]) * 39'(lbsb_pkg::DIV_RECIP);
    quo   = qp[38:23];
    tgt   = (quo > 16'(lbsb_pkg::HEIGHT_MAX)) ? lbsb_pkg::HEIGHT_MAX : quo[11:0];
    dec_p = 20'(10'd64 + 10'(speed_q)) * 20'(frame_dt_i) + 20'd64;
  end

  assign frame_take_o = (st_q == ST_IDLE) & frame_valid_i;
  assign empty_o = ~out_v_q;
  assign height_o = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (frame_valid_i) st_d = ST_LOAD;
      ST_LOAD: st_d = ST_SQRT;
      ST_SQRT: if (bit_q[0]) st_d = ST_NORM;
      ST_NORM: if (x_q[32]) st_d = ST_LOG;
      ST_LOG:  if (cnt_q == 5'd15) st_d = ST_DB;
      ST_DB:   st_d = ST_CMP;
      ST_CMP:  st_d = ST_DIV;
      ST_DIV:  st_d = (band_q == BW'(NUM_BANDS - 1)) ? ST_OUT : ST_LOAD;
      ST_OUT:  if (!out_v_q) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      sens_q  <= 7'd50;
      speed_q <= 9'd128;
      out_v_q <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) bars_q[b] <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lbsb_pkg::REG_SENS:  sens_q  <= cfg_wdata_i[lbsb_pkg::SENS_W-1:0];
          lbsb_pkg::REG_SPEED: speed_q <= cfg_wdata_i[lbsb_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
      if (st_q == ST_OUT && !out_v_q) out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
      if (st_q == ST_DIV) begin
        if (db_q > {1'b0, thr} && tgt > bars_q[band_q]) bars_q[band_q] <= tgt;
        else begin
          bars_q[band_q] <= ({1'b0, bars_q[band_q]} > decay_q) ?
                            12'({1'b0, bars_q[band_q]} - decay_q) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        band_q  <= '0;
        peaks_q <= frame_peak_i;
        decay_q <= dec_p[19:7];
      end
      ST_LOAD: begin
        v_q   <= peaks_q[band_q];
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
      end
      ST_SQRT: begin
        v_q   <= v_nx;
        r_q   <= r_nx;
        bit_q <= bit_q >> 2;
        x_q   <= r_nx[32:0] + 33'd1;
        e_q   <= 6'd32;
      end
      ST_NORM: begin
        if (!x_q[32]) begin
          x_q <= x_q << 1;
          e_q <= e_q - 1'b1;
        end
        m_q   <= x_q[32:2];
        cnt_q <= '0;
      end
      ST_LOG: begin
        m_q    <= sq[61] ? sq[61:31] : sq[60:30];
        frac_q <= {frac_q[14:0], sq[61]};
        cnt_q  <= cnt_q + 1'b1;
      end
      ST_DB: db_q <= DW'(dbp[40:16]);
      ST_CMP: num_q <= DW'(db_q - DW'(thr) + DW'(480));
      ST_DIV: band_q <= band_q + 1'b1;
      ST_OUT: begin
        if (!out_v_q) begin
          for (int j = 0; j < lbsb_pkg::NUM_OUT; j++)
            res_q[j] <= (j < NUM_BANDS) ? bars_q[j % NUM_BANDS] : '0;
        end
      end
      default: ;
    endcase
  end

endmodule
